// File: hw/rtl/gwms_pkg.sv
// Shared types, constants and helper functions of the Gaussian mirror smoother.
package gwms_pkg;

    localparam int CW         = 32;
    localparam int SEEN_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int HW_W       = 5;
    localparam int RATE_W     = 32;
    localparam int INV_W      = 17;

    localparam logic [SEEN_W-1:0] SEEN_MAX = 6'd63;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_RATE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_WINDOW  = 2'd2;

    localparam logic [HW_W-1:0]   HW_RESET   = 5'd1;
    localparam logic [RATE_W-1:0] RATE_RESET = 32'd16777216;
    localparam logic [INV_W-1:0]  INV_RESET  = 17'd21845;

    localparam logic [30:0] ONE30     = 31'h4000_0000;
    localparam logic [47:0] HALF30    = 48'h0000_2000_0000;
    localparam logic [16:0] W_ONE     = 17'h1_0000;
    localparam logic [79:0] T_LIMIT   = 80'h0000_0000_0BFF_FFFF_FFFF;
    localparam logic [3:0]  POLY_ORDER = 4'd8;

    typedef logic [4:0] op_t;

    localparam op_t OP_NONE      = 5'd0;
    localparam op_t OP_LOAD      = 5'd1;
    localparam op_t OP_CEN_FIRST = 5'd2;
    localparam op_t OP_CEN_NEXT  = 5'd3;
    localparam op_t OP_RD_C      = 5'd4;
    localparam op_t OP_CAP_C     = 5'd5;
    localparam op_t OP_CAP_S     = 5'd6;
    localparam op_t OP_ENT_RD    = 5'd7;
    localparam op_t OP_ENT_DIFF  = 5'd8;
    localparam op_t OP_ENT_SQ    = 5'd9;
    localparam op_t OP_ENT_MUL   = 5'd10;
    localparam op_t OP_ENT_T     = 5'd11;
    localparam op_t OP_POLY_MUL  = 5'd12;
    localparam op_t OP_POLY_DIV  = 5'd13;
    localparam op_t OP_ENT_WT    = 5'd14;
    localparam op_t OP_ENT_TERM  = 5'd15;
    localparam op_t OP_ENT_ACC   = 5'd16;
    localparam op_t OP_FIN_MUL   = 5'd17;
    localparam op_t OP_FIN_OUT   = 5'd18;

    typedef struct packed {
        logic signed [CW-1:0] x_pos;
        logic signed [CW-1:0] y_val;
        logic                 last;
    } in_beat_t;

    typedef struct packed {
        logic signed [CW-1:0] x_out;
        logic signed [CW-1:0] y_smoothed;
        logic                 last_out;
    } out_beat_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic has_center;
        logic ent_last;
        logic poly_last;
        logic cen_last;
        logic out_free;
    } status_t;

    function automatic logic [16:0] exp_int(input logic [3:0] idx);
        logic [16:0] v;
        case (idx)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // ceil(2^33 / k): exact quotient of a 30-bit value after a shift by 33
    function automatic logic [33:0] recip(input logic [3:0] k);
        logic [33:0] v;
        case (k)
            4'd1:    v = 34'd8589934592;
            4'd2:    v = 34'd4294967296;
            4'd3:    v = 34'd2863311531;
            4'd4:    v = 34'd2147483648;
            4'd5:    v = 34'd1717986919;
            4'd6:    v = 34'd1431655766;
            4'd7:    v = 34'd1227133514;
            4'd8:    v = 34'd1073741824;
            default: v = 34'd0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/gwms_ctrl.sv
// Sequencer that steps the smoother datapath through loads, centers and window entries.
module gwms_ctrl
    import gwms_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output cmd_t    cmd,
    input  status_t stat
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DECIDE = 5'd1;
    localparam logic [4:0] S_NEXT   = 5'd2;
    localparam logic [4:0] S_RDC    = 5'd3;
    localparam logic [4:0] S_CAPC   = 5'd4;
    localparam logic [4:0] S_CAPS   = 5'd5;
    localparam logic [4:0] S_RD     = 5'd6;
    localparam logic [4:0] S_DIFF   = 5'd7;
    localparam logic [4:0] S_SQ     = 5'd8;
    localparam logic [4:0] S_MUL    = 5'd9;
    localparam logic [4:0] S_T      = 5'd10;
    localparam logic [4:0] S_PMUL   = 5'd11;
    localparam logic [4:0] S_PDIV   = 5'd12;
    localparam logic [4:0] S_WT     = 5'd13;
    localparam logic [4:0] S_TERM   = 5'd14;
    localparam logic [4:0] S_ACC    = 5'd15;
    localparam logic [4:0] S_FMUL   = 5'd16;
    localparam logic [4:0] S_FOUT   = 5'd17;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.has_center)
                begin
                    cmd.op     = OP_CEN_FIRST;
                    state_next = S_RDC;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_NEXT:
            begin
                cmd.op     = OP_CEN_NEXT;
                state_next = S_RDC;
            end
            S_RDC:
            begin
                cmd.op     = OP_RD_C;
                state_next = S_CAPC;
            end
            S_CAPC:
            begin
                cmd.op     = OP_CAP_C;
                state_next = S_CAPS;
            end
            S_CAPS:
            begin
                cmd.op     = OP_CAP_S;
                state_next = S_RD;
            end
            S_RD:
            begin
                cmd.op     = OP_ENT_RD;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.op     = OP_ENT_DIFF;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.op     = OP_ENT_SQ;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op     = OP_ENT_MUL;
                state_next = S_T;
            end
            S_T:
            begin
                cmd.op     = OP_ENT_T;
                state_next = S_PMUL;
            end
            S_PMUL:
            begin
                cmd.op     = OP_POLY_MUL;
                state_next = S_PDIV;
            end
            S_PDIV:
            begin
                cmd.op     = OP_POLY_DIV;
                state_next = stat.poly_last ? S_WT : S_PMUL;
            end
            S_WT:
            begin
                cmd.op     = OP_ENT_WT;
                state_next = S_TERM;
            end
            S_TERM:
            begin
                cmd.op     = OP_ENT_TERM;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.op     = OP_ENT_ACC;
                state_next = stat.ent_last ? S_FMUL : S_RD;
            end
            S_FMUL:
            begin
                cmd.op     = OP_FIN_MUL;
                state_next = S_FOUT;
            end
            S_FOUT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_FIN_OUT;
                    state_next = stat.cen_last ? S_IDLE : S_NEXT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/gwms_dpath.sv
// Datapath: config registers, sample window memory, weight unit, accumulator, output beat.
module gwms_dpath
    import gwms_pkg::*;
#(
    parameter int NHOOD_MAX = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_beat_t              in_data,
    input  cmd_t                  cmd,
    output status_t               stat,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_beat_t             out_data
);

    localparam int DEPTH = 2 * NHOOD_MAX + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(NHOOD_MAX + 1);
    localparam int OW    = ((AW > SEEN_W) ? AW : SEEN_W) + 2;

    logic [HW_W-1:0]   hw_reg;
    logic [RATE_W-1:0] rate_reg;
    logic [INV_W-1:0]  inv_reg;

    logic [2*CW-1:0] win_mem [DEPTH];
    logic [2*CW-1:0] rd_data_reg;
    logic [AW-1:0]   rd_addr;

    logic [AW-1:0]     head_reg;
    logic [AW-1:0]     head_inc;
    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] s_reg;
    logic [NW-1:0]     nn_reg;
    logic [NW-1:0]     nn_cur;
    logic              last_reg;
    logic signed [CW-1:0] x0_reg;

    logic [NW-1:0] d_reg;
    logic [AW-1:0] j_reg;
    logic signed [CW-1:0] xc_reg;
    logic signed [CW-1:0] yc_reg;
    logic signed [CW-1:0] xs_reg;
    logic mir_lo_reg;
    logic mir_hi_reg;

    logic [CW+2:0]        a_reg;
    logic signed [CW:0]   ydiff_reg;
    logic                 big_reg;
    logic [2*CW-17:0]     dsq_reg;
    logic [47:0]          ph_reg;
    logic [63:0]          pl_reg;
    logic [19:0]          t_reg;
    logic                 zero_reg;
    logic [3:0]           k_reg;
    logic [30:0]          p_reg;
    logic [29:0]          v_reg;
    logic [16:0]          w_reg;
    logic [33:0]          tm_reg;
    logic                 tneg_reg;
    logic signed [40:0]   acc_reg;
    logic [57:0]          fm_reg;
    logic                 fneg_reg;
    out_beat_t            out_reg;
    logic                 out_valid_reg;

    logic signed [CW-1:0] rd_x;
    logic signed [CW-1:0] rd_y;
    assign rd_x = rd_data_reg[2*CW-1:CW];
    assign rd_y = rd_data_reg[CW-1:0];

    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;

    always_comb
    begin
        if (hw_reg == '0)
        begin
            nn_cur = NW'(1);
        end
        else if (hw_reg > HW_W'(NHOOD_MAX))
        begin
            nn_cur = NW'(NHOOD_MAX);
        end
        else
        begin
            nn_cur = hw_reg[NW-1:0];
        end
    end

    function automatic logic [AW-1:0] slot_addr(input logic [AW-1:0] head,
                                                 input logic [AW-1:0] idx);
        logic [AW:0] wrap;
        wrap = {1'b0, head} + (AW+1)'(DEPTH) - {1'b0, idx};
        if (head >= idx)
        begin
            return head - idx;
        end
        return wrap[AW-1:0];
    endfunction

    logic signed [OW-1:0] o_w;
    logic signed [OW-1:0] sv_w;
    logic signed [OW-1:0] m_w;
    logic signed [OW-1:0] src_w;
    logic                 lo_w;
    logic                 hi_w;
    logic [AW-1:0]        s_slot;

    always_comb
    begin
        o_w   = $signed(OW'(d_reg)) - $signed(OW'(nn_reg)) + $signed(OW'(j_reg));
        sv_w  = $signed(OW'(s_reg));
        m_w   = '0;
        lo_w  = 1'b0;
        hi_w  = 1'b0;
        if (o_w < 0)
        begin
            m_w = -o_w;
            if (m_w > sv_w)
            begin
                m_w = sv_w;
            end
            src_w = m_w;
            lo_w  = 1'b1;
        end
        else if (o_w > sv_w)
        begin
            m_w = o_w - sv_w;
            if (m_w > sv_w)
            begin
                m_w = sv_w;
            end
            src_w = sv_w - m_w;
            hi_w  = 1'b1;
        end
        else
        begin
            src_w = o_w;
        end
    end

    assign s_slot = (s_reg > SEEN_W'(DEPTH - 1)) ? AW'(DEPTH - 1) : s_reg[AW-1:0];

    always_comb
    begin
        case (cmd.op)
            OP_RD_C:   rd_addr = slot_addr(head_reg, AW'(d_reg));
            OP_CAP_C:  rd_addr = slot_addr(head_reg, s_slot);
            OP_ENT_RD: rd_addr = slot_addr(head_reg, src_w[AW-1:0]);
            default:   rd_addr = head_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            win_mem[head_inc] <= {in_data.x_pos, in_data.y_val};
        end
        rd_data_reg <= win_mem[rd_addr];
    end

    logic signed [CW+1:0] xj_w;
    logic signed [CW+2:0] dx_w;
    logic [63:0]          sq_w;
    logic [47:0]          ph_w;
    logic [63:0]          pl_w;
    logic [79:0]          prod_w;
    logic [46:0]          fp_w;
    logic [63:0]          vq_w;
    logic [47:0]          ep_w;
    logic [16:0]          wr_w;
    logic [CW:0]          ymag_w;
    logic [49:0]          ym_w;
    logic [40:0]          amag_w;
    logic [57:0]          fm_w;
    logic signed [42:0]   sres_w;
    logic signed [42:0]   ysum_w;
    logic signed [CW-1:0] ysat_w;

    always_comb
    begin
        if (mir_lo_reg)
        begin
            xj_w = $signed({x0_reg[CW-1], x0_reg, 1'b0}) - (CW+2)'(rd_x);
        end
        else if (mir_hi_reg)
        begin
            xj_w = $signed({xs_reg[CW-1], xs_reg, 1'b0}) - (CW+2)'(rd_x);
        end
        else
        begin
            xj_w = (CW+2)'(rd_x);
        end
        dx_w   = (CW+3)'(xj_w) - (CW+3)'(xc_reg);
        sq_w   = a_reg[CW-1:0] * a_reg[CW-1:0];
        ph_w   = dsq_reg[2*CW-17:CW] * rate_reg;
        pl_w   = dsq_reg[CW-1:0] * rate_reg;
        prod_w = {ph_w, 32'b0} + 80'(pl_w);
        fp_w   = t_reg[15:0] * p_reg;
        vq_w   = v_reg * recip(k_reg);
        ep_w   = exp_int(t_reg[19:16]) * p_reg + HALF30;
        if (rate_reg == '0)
        begin
            wr_w = W_ONE;
        end
        else if (zero_reg)
        begin
            wr_w = '0;
        end
        else
        begin
            wr_w = ep_w[46:30];
        end
        ymag_w = ydiff_reg[CW] ? (CW+1)'(-ydiff_reg) : (CW+1)'(ydiff_reg);
        ym_w   = ymag_w * w_reg + 50'h8000;
        amag_w = acc_reg[40] ? 41'(-acc_reg) : 41'(acc_reg);
        fm_w   = amag_w * inv_reg + 58'h8000;
        sres_w = fneg_reg ? -$signed({1'b0, fm_reg[57:16]}) : $signed({1'b0, fm_reg[57:16]});
        ysum_w = 43'(yc_reg) + sres_w;
        if (ysum_w > 43'sh0_7FFF_FFFF)
        begin
            ysat_w = 32'sh7FFF_FFFF;
        end
        else if (ysum_w < -43'sh0_8000_0000)
        begin
            ysat_w = -32'sh8000_0000;
        end
        else
        begin
            ysat_w = ysum_w[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg        <= HW_RESET;
            rate_reg      <= RATE_RESET;
            inv_reg       <= INV_RESET;
            head_reg      <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HALF_WINDOW: hw_reg   <= cfg_data[HW_W-1:0];
                    REG_EXP_RATE:    rate_reg <= cfg_data[RATE_W-1:0];
                    REG_INV_WINDOW:  inv_reg  <= cfg_data[INV_W-1:0];
                    default:         ;
                endcase
            end
            if (cmd.op == OP_LOAD)
            begin
                head_reg <= head_inc;
                if (in_data.last)
                begin
                    seen_reg <= '0;
                end
                else if (seen_reg != SEEN_MAX)
                begin
                    seen_reg <= seen_reg + 1'b1;
                end
            end
            if (cmd.op == OP_FIN_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                x0_reg   <= in_data.x_pos;
                last_reg <= in_data.last;
                s_reg    <= seen_reg;
                nn_reg   <= nn_cur;
            end
            OP_CEN_FIRST:
            begin
                if (last_reg && (s_reg < SEEN_W'(nn_reg)))
                begin
                    d_reg <= s_reg[NW-1:0];
                end
                else
                begin
                    d_reg <= nn_reg;
                end
            end
            OP_CEN_NEXT:
            begin
                d_reg <= d_reg - 1'b1;
            end
            OP_CAP_C:
            begin
                xc_reg <= rd_x;
                yc_reg <= rd_y;
            end
            OP_CAP_S:
            begin
                xs_reg  <= rd_x;
                j_reg   <= '0;
                acc_reg <= '0;
            end
            OP_ENT_RD:
            begin
                mir_lo_reg <= lo_w;
                mir_hi_reg <= hi_w;
            end
            OP_ENT_DIFF:
            begin
                a_reg     <= dx_w[CW+2] ? (CW+3)'(-dx_w) : (CW+3)'(dx_w);
                ydiff_reg <= (CW+1)'(rd_y) - (CW+1)'(yc_reg);
            end
            OP_ENT_SQ:
            begin
                big_reg <= (a_reg[CW+2:CW] != '0);
                dsq_reg <= sq_w[63:16];
            end
            OP_ENT_MUL:
            begin
                ph_reg <= ph_w;
                pl_reg <= pl_w;
            end
            OP_ENT_T:
            begin
                zero_reg <= big_reg || ({ph_reg, 32'b0} + 80'(pl_reg) > T_LIMIT);
                t_reg    <= prod_w[43:24];
                p_reg    <= ONE30;
                k_reg    <= POLY_ORDER;
            end
            OP_POLY_MUL:
            begin
                v_reg <= fp_w[45:16];
            end
            OP_POLY_DIV:
            begin
                p_reg <= ONE30 - vq_w[63:33];
                k_reg <= k_reg - 1'b1;
            end
            OP_ENT_WT:
            begin
                w_reg <= wr_w;
            end
            OP_ENT_TERM:
            begin
                tm_reg   <= ym_w[49:16];
                tneg_reg <= ydiff_reg[CW];
            end
            OP_ENT_ACC:
            begin
                acc_reg <= tneg_reg ? acc_reg - $signed(41'(tm_reg))
                                    : acc_reg + $signed(41'(tm_reg));
                j_reg   <= j_reg + 1'b1;
            end
            OP_FIN_MUL:
            begin
                fm_reg   <= fm_w;
                fneg_reg <= acc_reg[40];
            end
            OP_FIN_OUT:
            begin
                out_reg.x_out      <= xc_reg;
                out_reg.y_smoothed <= ysat_w;
                out_reg.last_out   <= last_reg && (d_reg == '0);
            end
            default:
            begin
            end
        endcase
    end

    assign stat.has_center = last_reg || (s_reg >= SEEN_W'(nn_reg));
    assign stat.ent_last   = (j_reg == AW'({nn_reg, 1'b0}));
    assign stat.poly_last  = (k_reg == 4'd1);
    assign stat.cen_last   = !last_reg || (d_reg == '0);
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: hw/rtl/gauss_weighted_mirror_smoother_core.sv
// Top level of the Gaussian weighted mirror smoother: sequencer plus datapath.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------
//  in      | input     | in_valid / in_ready    | in_data  (x_pos,y_val,last)
//  out     | output    | out_valid / out_ready  | out_data (x_out,y_smoothed,last_out)
//  cfg     | input     | cfg_we, no wait        | cfg_index, cfg_data
//
// Each center runs each of its 2n+1 window entries once through the shared square,
// rate multiply and eight-step Horner unit; an input passes the load and decide
// states first, and an input that yields no center returns to idle from decide.
// A last beat flushes min(seen,n)+1 centers back to back through the same unit.
// in_ready is high only while the sequencer is idle; a result still waiting in the
// output register holds the sequencer before the next result until out_ready.
// Reset clears sequencer, head, seen, out_valid; config gets defaults; memory is kept.
module gauss_weighted_mirror_smoother_core
    import gwms_pkg::*;
#(
    parameter int NHOOD_MAX = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_beat_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_beat_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t stat;

    gwms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    gwms_dpath #(
        .NHOOD_MAX (NHOOD_MAX)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// File: hw/rtl/gwms_checker.sv
// Port-level checker for the smoother core and its bind.
module gwms_checker
    import gwms_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_beat_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_beat_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped before the beat was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("out_data changed while stalled");

    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after a beat");

    a_no_instant_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared one cycle after an input beat");

endmodule

bind gauss_weighted_mirror_smoother_core gwms_checker u_gwms_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
